@@ hdl/lcdr_pkg.sv @@
// Shared types and constants for the character LCD controller register block.
`default_nettype none

package lcdr_pkg;

    // Sizes of the two stores and of the request queue.
    localparam int DISPLAY_CELLS_DEF = 80;
    localparam int LINE_CELLS_DEF    = 40;
    localparam int GLYPH_ROWS        = 64;
    localparam int GLYPH_AW          = $clog2(GLYPH_ROWS);
    localparam int QUEUE_DEPTH       = 2;
    localparam int QUEUE_AW          = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW          = $clog2(QUEUE_DEPTH + 1);

    // Instruction byte masks and match values, checked in priority order.
    localparam logic [7:0] FSET_MASK  = 8'hE0;
    localparam logic [7:0] FSET_CODE  = 8'h20;
    localparam logic [7:0] DCTL_MASK  = 8'hF8;
    localparam logic [7:0] DCTL_CODE  = 8'h08;
    localparam logic [7:0] CLEAR_CODE = 8'h01;
    localparam logic [7:0] HOME_MASK  = 8'hFE;
    localparam logic [7:0] HOME_CODE  = 8'h02;
    localparam logic [7:0] ENTRY_MASK = 8'hFC;
    localparam logic [7:0] ENTRY_CODE = 8'h04;
    localparam logic [7:0] CGA_MASK   = 8'hC0;
    localparam logic [7:0] CGA_CODE   = 8'h40;

    // Cell code that an unwritten or cleared display cell holds.
    localparam logic [7:0] SPACE_CODE = 8'h20;

    // Request types on the input channel.
    typedef enum logic [1:0] {
        REQ_INSTR    = 2'd0,
        REQ_DATA     = 2'd1,
        REQ_RD_DISP  = 2'd2,
        REQ_RD_GLYPH = 2'd3
    } t_req_type;

    // Classified command handed from the front end to the execution side.
    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_FSET,
        CMD_DCTL,
        CMD_CLEAR,
        CMD_HOME,
        CMD_ENTRY,
        CMD_CGA,
        CMD_DDA,
        CMD_DATA,
        CMD_RD_DISP,
        CMD_RD_GLYPH
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
        logic [6:0] index;
    } t_cmd;

    // Execution side states.
    typedef enum logic {
        BK_IDLE,
        BK_READ
    } t_back_state;

endpackage

`default_nettype wire

@@ hdl/lcdr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lcdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/lcdr_front.sv @@
// Front end: accepts requests, decodes instructions and registers the command.
`default_nettype none

module lcdr_front
    import lcdr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_req_type,
    input  wire logic [7:0] i_write_byte,
    input  wire logic [6:0] i_read_index,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_cmd            o_cmd
);

    logic      r_valid;
    t_cmd      r_cmd;
    t_cmd_kind instr_kind;
    t_cmd_kind req_kind;
    logic      accept;

    // Instruction decode in priority order; anything unmatched does nothing.
    always_comb begin
        if ((i_write_byte & FSET_MASK) == FSET_CODE) begin
            instr_kind = CMD_FSET;
        end else if ((i_write_byte & DCTL_MASK) == DCTL_CODE) begin
            instr_kind = CMD_DCTL;
        end else if (i_write_byte == CLEAR_CODE) begin
            instr_kind = CMD_CLEAR;
        end else if ((i_write_byte & HOME_MASK) == HOME_CODE) begin
            instr_kind = CMD_HOME;
        end else if ((i_write_byte & ENTRY_MASK) == ENTRY_CODE) begin
            instr_kind = CMD_ENTRY;
        end else if ((i_write_byte & CGA_MASK) == CGA_CODE) begin
            instr_kind = CMD_CGA;
        end else if (i_write_byte[7]) begin
            instr_kind = CMD_DDA;
        end else begin
            instr_kind = CMD_NOP;
        end
    end

    // Request type decode.
    always_comb begin
        unique case (t_req_type'(i_req_type))
            REQ_INSTR:    req_kind = instr_kind;
            REQ_DATA:     req_kind = CMD_DATA;
            REQ_RD_DISP:  req_kind = CMD_RD_DISP;
            REQ_RD_GLYPH: req_kind = CMD_RD_GLYPH;
            default:      req_kind = CMD_NOP;
        endcase
    end

    // The holding register drains into the queue whenever the queue has room.
    assign o_push  = r_valid && !i_q_full;
    assign o_stall = r_valid && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.kind  <= req_kind;
            r_cmd.data  <= i_write_byte;
            r_cmd.index <= i_read_index;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lcdr_fifo.sv @@
// Short command queue between the front end and the execution side.
`default_nettype none

module lcdr_fifo
    import lcdr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lcdr_back.sv @@
// Execution side: register file, display and glyph stores, result register.
`default_nettype none

module lcdr_back
    import lcdr_pkg::*;
#(
    parameter int DISPLAY_CELLS = DISPLAY_CELLS_DEF,
    parameter int LINE_CELLS    = LINE_CELLS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  t_cmd      i_q_cmd,
    output logic      o_pop,
    output logic       o_valid,
    input  wire logic  i_stall,
    output logic [7:0] o_read_value,
    output logic [6:0] o_display_address,
    output logic [5:0] o_glyph_address,
    output logic       o_target_display,
    output logic       o_two_line,
    output logic       o_display_on,
    output logic       o_cursor_on,
    output logic       o_blink_on,
    output logic       o_count_up,
    output logic       o_shift_on,
    output logic       o_wide_bus,
    output logic       o_tall_font
);

    localparam int         DISP_AW = $clog2(DISPLAY_CELLS);
    localparam logic [7:0] CELLS8  = 8'(DISPLAY_CELLS);
    localparam logic [7:0] LINE8   = 8'(LINE_CELLS);
    localparam logic [6:0] GROWS7  = 7'(GLYPH_ROWS);

    t_back_state r_state, n_state;

    // Register file.
    logic [6:0]          r_disp_addr, n_disp_addr;
    logic [GLYPH_AW-1:0] r_glyph_addr, n_glyph_addr;
    logic r_sel, n_sel;
    logic r_two_line, n_two_line;
    logic r_display_on, n_display_on;
    logic r_cursor_on, n_cursor_on;
    logic r_blink_on, n_blink_on;
    logic r_count_up, n_count_up;
    logic r_shift_on, n_shift_on;
    logic r_wide_bus, n_wide_bus;
    logic r_tall_font, n_tall_font;

    // Result register and read bookkeeping.
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_read_value, n_read_value;
    logic       r_rd_glyph, n_rd_glyph;
    logic       r_rd_range, n_rd_range;
    logic       r_rd_hit, n_rd_hit;

    // Valid bits standing in for the reset contents of both stores.
    logic [DISPLAY_CELLS-1:0] r_disp_valid;
    logic [GLYPH_ROWS-1:0]    r_glyph_valid;

    // Store controls.
    logic               disp_we, disp_re, disp_clear;
    logic [DISP_AW-1:0] disp_waddr, disp_raddr;
    logic               glyph_we, glyph_re;
    logic [GLYPH_AW-1:0] glyph_raddr;
    logic [7:0]         disp_rdata;
    logic [4:0]         glyph_rdata;

    logic       out_free;
    logic [7:0] line_idx;
    logic [7:0] wr_idx;
    logic       wr_ok;
    logic       rd_disp_range;

    lcdr_ram #(
        .WIDTH(8),
        .DEPTH(DISPLAY_CELLS)
    ) u_disp_ram (
        .i_clk  (i_clk),
        .i_we   (disp_we),
        .i_waddr(disp_waddr),
        .i_wdata(i_q_cmd.data),
        .i_re   (disp_re),
        .i_raddr(disp_raddr),
        .o_rdata(disp_rdata)
    );

    lcdr_ram #(
        .WIDTH(5),
        .DEPTH(GLYPH_ROWS)
    ) u_glyph_ram (
        .i_clk  (i_clk),
        .i_we   (glyph_we),
        .i_waddr(r_glyph_addr),
        .i_wdata(i_q_cmd.data[4:0]),
        .i_re   (glyph_re),
        .i_raddr(glyph_raddr),
        .o_rdata(glyph_rdata)
    );

    // Display write index: line and offset in two-line mode, flat otherwise.
    assign line_idx = {2'b00, r_disp_addr[5:0]} + (r_disp_addr[6] ? LINE8 : 8'd0);
    always_comb begin
        if (r_two_line) begin
            wr_idx = line_idx;
            wr_ok  = ({2'b00, r_disp_addr[5:0]} < LINE8) && (line_idx < CELLS8);
        end else begin
            wr_idx = {1'b0, r_disp_addr};
            wr_ok  = ({1'b0, r_disp_addr} < CELLS8);
        end
    end

    assign disp_waddr    = wr_idx[DISP_AW-1:0];
    assign disp_raddr    = i_q_cmd.index[DISP_AW-1:0];
    assign glyph_raddr   = i_q_cmd.index[GLYPH_AW-1:0];
    assign rd_disp_range = ({1'b0, i_q_cmd.index} < CELLS8);
    assign out_free      = !r_out_valid || !i_stall;

    // Next state, store controls and result formation.
    always_comb begin
        n_state      = r_state;
        n_disp_addr  = r_disp_addr;
        n_glyph_addr = r_glyph_addr;
        n_sel        = r_sel;
        n_two_line   = r_two_line;
        n_display_on = r_display_on;
        n_cursor_on  = r_cursor_on;
        n_blink_on   = r_blink_on;
        n_count_up   = r_count_up;
        n_shift_on   = r_shift_on;
        n_wide_bus   = r_wide_bus;
        n_tall_font  = r_tall_font;
        n_out_valid  = r_out_valid && i_stall;
        n_read_value = r_read_value;
        n_rd_glyph   = r_rd_glyph;
        n_rd_range   = r_rd_range;
        n_rd_hit     = r_rd_hit;
        o_pop        = 1'b0;
        disp_we      = 1'b0;
        disp_re      = 1'b0;
        disp_clear   = 1'b0;
        glyph_we     = 1'b0;
        glyph_re     = 1'b0;

        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_pop        = 1'b1;
                    n_out_valid  = 1'b1;
                    n_read_value = '0;
                    case (i_q_cmd.kind)
                        CMD_FSET: begin
                            n_wide_bus  = i_q_cmd.data[4];
                            n_two_line  = i_q_cmd.data[3];
                            n_tall_font = i_q_cmd.data[2];
                        end
                        CMD_DCTL: begin
                            n_display_on = i_q_cmd.data[2];
                            n_cursor_on  = i_q_cmd.data[1];
                            n_blink_on   = i_q_cmd.data[0];
                        end
                        CMD_CLEAR: begin
                            disp_clear  = 1'b1;
                            n_disp_addr = '0;
                            n_count_up  = 1'b1;
                        end
                        CMD_HOME: begin
                            n_disp_addr = '0;
                        end
                        CMD_ENTRY: begin
                            n_count_up = i_q_cmd.data[1];
                            n_shift_on = i_q_cmd.data[0];
                        end
                        CMD_CGA: begin
                            n_glyph_addr = i_q_cmd.data[GLYPH_AW-1:0];
                            n_sel        = 1'b0;
                        end
                        CMD_DDA: begin
                            n_disp_addr = i_q_cmd.data[6:0];
                            n_sel       = 1'b1;
                        end
                        CMD_DATA: begin
                            if (r_sel) begin
                                disp_we     = wr_ok;
                                n_disp_addr = r_count_up ? r_disp_addr + 7'd1
                                                         : r_disp_addr - 7'd1;
                            end else begin
                                glyph_we     = 1'b1;
                                n_glyph_addr = r_count_up ? r_glyph_addr + 1'b1
                                                          : r_glyph_addr - 1'b1;
                            end
                        end
                        CMD_RD_DISP: begin
                            n_out_valid = 1'b0;
                            n_state     = BK_READ;
                            disp_re     = rd_disp_range;
                            n_rd_glyph  = 1'b0;
                            n_rd_range  = rd_disp_range;
                            n_rd_hit    = r_disp_valid[disp_raddr];
                        end
                        CMD_RD_GLYPH: begin
                            n_out_valid = 1'b0;
                            n_state     = BK_READ;
                            glyph_re    = 1'b1;
                            n_rd_glyph  = 1'b1;
                            n_rd_range  = (i_q_cmd.index < GROWS7);
                            n_rd_hit    = r_glyph_valid[glyph_raddr];
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BK_READ: begin
                // Store data is registered now; finish once the result slot frees.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = BK_IDLE;
                    if (!r_rd_range) begin
                        n_read_value = '0;
                    end else if (r_rd_glyph) begin
                        n_read_value = r_rd_hit ? {3'b000, glyph_rdata} : 8'd0;
                    end else begin
                        n_read_value = r_rd_hit ? disp_rdata : SPACE_CODE;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Control state and registers with reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= BK_IDLE;
            r_out_valid   <= 1'b0;
            r_disp_addr   <= '0;
            r_glyph_addr  <= '0;
            r_sel         <= 1'b0;
            r_two_line    <= 1'b0;
            r_display_on  <= 1'b0;
            r_cursor_on   <= 1'b0;
            r_blink_on    <= 1'b0;
            r_count_up    <= 1'b1;
            r_shift_on    <= 1'b0;
            r_wide_bus    <= 1'b0;
            r_tall_font   <= 1'b0;
            r_disp_valid  <= '0;
            r_glyph_valid <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_disp_addr  <= n_disp_addr;
            r_glyph_addr <= n_glyph_addr;
            r_sel        <= n_sel;
            r_two_line   <= n_two_line;
            r_display_on <= n_display_on;
            r_cursor_on  <= n_cursor_on;
            r_blink_on   <= n_blink_on;
            r_count_up   <= n_count_up;
            r_shift_on   <= n_shift_on;
            r_wide_bus   <= n_wide_bus;
            r_tall_font  <= n_tall_font;
            if (disp_clear) begin
                r_disp_valid <= '0;
            end else if (disp_we) begin
                r_disp_valid[disp_waddr] <= 1'b1;
            end
            if (glyph_we) begin
                r_glyph_valid[r_glyph_addr] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_read_value <= n_read_value;
        r_rd_glyph   <= n_rd_glyph;
        r_rd_range   <= n_rd_range;
        r_rd_hit     <= n_rd_hit;
    end

    // The register file only moves when a new result is loaded, so it is the payload.
    assign o_valid           = r_out_valid;
    assign o_read_value      = r_read_value;
    assign o_display_address = r_disp_addr;
    assign o_glyph_address   = r_glyph_addr;
    assign o_target_display  = r_sel;
    assign o_two_line        = r_two_line;
    assign o_display_on      = r_display_on;
    assign o_cursor_on       = r_cursor_on;
    assign o_blink_on        = r_blink_on;
    assign o_count_up        = r_count_up;
    assign o_shift_on        = r_shift_on;
    assign o_wide_bus        = r_wide_bus;
    assign o_tall_font       = r_tall_font;

endmodule

`default_nettype wire

@@ hdl/char_lcd_controller_registers_unit.sv @@
// Top level of the character LCD controller register block.
//
//   Channel   Direction   Handshake            Payload
//   request   in          i_valid / o_stall    i_req_type, i_write_byte, i_read_index
//   result    out         o_valid / i_stall    o_read_value and the register file
//
// A request is registered in the front-end register, then in the queue, then executed into
// the result register; a read first passes the BK_READ state for the registered store read.
// Writes sustain one per cycle while the result channel is not stalled.
// Clear drops the display valid bits at once, no fill pass.
// Reset is synchronous and active low; it clears control state and all valid bits.
// A stalled result holds the execution side; queue and front register fill, o_stall rises.
`default_nettype none

module char_lcd_controller_registers_unit
    import lcdr_pkg::*;
#(
    parameter int DISPLAY_CELLS = DISPLAY_CELLS_DEF,
    parameter int LINE_CELLS    = LINE_CELLS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_req_type,
    input  wire logic [7:0] i_write_byte,
    input  wire logic [6:0] i_read_index,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_read_value,
    output logic [6:0]      o_display_address,
    output logic [5:0]      o_glyph_address,
    output logic            o_target_display,
    output logic            o_two_line,
    output logic            o_display_on,
    output logic            o_cursor_on,
    output logic            o_blink_on,
    output logic            o_count_up,
    output logic            o_shift_on,
    output logic            o_wide_bus,
    output logic            o_tall_font
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    t_cmd front_cmd;
    t_cmd q_cmd;

    lcdr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req_type  (i_req_type),
        .i_write_byte(i_write_byte),
        .i_read_index(i_read_index),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (front_cmd)
    );

    lcdr_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (front_cmd),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_cmd  (q_cmd)
    );

    lcdr_back #(
        .DISPLAY_CELLS(DISPLAY_CELLS),
        .LINE_CELLS   (LINE_CELLS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_cmd          (q_cmd),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_read_value     (o_read_value),
        .o_display_address(o_display_address),
        .o_glyph_address  (o_glyph_address),
        .o_target_display (o_target_display),
        .o_two_line       (o_two_line),
        .o_display_on     (o_display_on),
        .o_cursor_on      (o_cursor_on),
        .o_blink_on       (o_blink_on),
        .o_count_up       (o_count_up),
        .o_shift_on       (o_shift_on),
        .o_wide_bus       (o_wide_bus),
        .o_tall_font      (o_tall_font)
    );

`ifndef SYNTHESIS
    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("command queue overflow");

    // No result is offered in the first cycle after reset.
    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

    // The address counters only move together with a new result.
    a_addr_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (!$stable(o_display_address) || !$stable(o_glyph_address)))
        |-> o_valid)
        else $error("address counter moved without a result");
`endif

endmodule

`default_nettype wire
